[hdl/mandelbrot_escape_time_pixel_defines.svh]
// ----------------------------------------------------------------------------
// mandelbrot escape-time pixel: assertion macros
// shared concurrent assertion forms, clocked and disabled during reset
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_DEFINES_SVH

// same-cycle property
`define MBET_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("mbet assertion failed");

// antecedent implies consequent in the next cycle
`define MBET_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mbet assertion failed");

`endif

[hdl/mbet_pkg.sv]
// ----------------------------------------------------------------------------
// mbet_pkg
// shared constants, command/status types and helper functions
// ----------------------------------------------------------------------------
package mbet_pkg;

  localparam int ITER_LIMIT   = 150;
  localparam int PALETTE_SIZE = 17;
  localparam int MAX_DIM      = 4096;

  localparam int Q_FRAC    = 28;
  localparam int Z_W       = 32;
  localparam int PROD_W    = 2 * Z_W;
  localparam int DIM_W     = 13;
  localparam int POS_W     = 12;
  localparam int DEN_W     = $clog2(MAX_DIM);
  localparam int TRI_W     = DEN_W + 2;
  localparam int DIV_STEPS = Q_FRAC + 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int ITER_W    = $clog2(ITER_LIMIT + 1);
  localparam int IDX_W     = 5;
  localparam int PAL_MOD   = PALETTE_SIZE - 1;
  localparam int COLOR_W   = 8;

  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  // register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);

  // -2.25 and -1.5 in q4.28
  localparam logic signed [Z_W-1:0] RE_MIN = -32'sd603979776;
  localparam logic signed [Z_W-1:0] IM_MIN = -32'sd402653184;

  // 4.0 in q8.56, one guard bit for the unsigned sum
  localparam logic [PROD_W:0] ESCAPE_Q = (PROD_W + 1)'(4) << (2 * Q_FRAC);

  typedef struct packed {
    logic load;
    logic div_step;
    logic mul;
    logic upd;
    logic out_load;
  } mbet_cmd_t;

  typedef struct packed {
    logic escape;
    logic k_last;
  } mbet_sts_t;

  typedef struct packed {
    logic [COLOR_W-1:0] r;
    logic [COLOR_W-1:0] g;
    logic [COLOR_W-1:0] b;
  } mbet_rgb_t;

  // dimension clamped to 2..MAX_DIM, minus one
  function automatic logic [DEN_W-1:0] den_of(logic [DIM_W-1:0] dim);
    logic [DIM_W-1:0] eff;
    if (dim < DIM_W'(2)) begin
      eff = DIM_W'(2);
    end else if (dim > DIM_W'(MAX_DIM)) begin
      eff = DIM_W'(MAX_DIM);
    end else begin
      eff = dim;
    end
    den_of = DEN_W'(eff - DIM_W'(1));
  endfunction

  // q8.56 to q4.28, round half up
  function automatic logic signed [Z_W-1:0] rescale(logic signed [PROD_W-1:0] v);
    logic [PROD_W-1:0] t;
    t = v + (PROD_W'(1) << (Q_FRAC - 1));
    rescale = t[Q_FRAC+Z_W-1:Q_FRAC];
  endfunction

  function automatic mbet_rgb_t palette_rgb(logic [IDX_W-1:0] idx);
    mbet_rgb_t c;
    case (idx)
      IDX_W'(0):  c = '{8'd0,   8'd0,   8'd0};
      IDX_W'(1):  c = '{8'd0,   8'd0,   8'd191};
      IDX_W'(2):  c = '{8'd0,   8'd0,   8'd255};
      IDX_W'(3):  c = '{8'd0,   8'd64,  8'd255};
      IDX_W'(4):  c = '{8'd0,   8'd128, 8'd255};
      IDX_W'(5):  c = '{8'd0,   8'd191, 8'd255};
      IDX_W'(6):  c = '{8'd0,   8'd255, 8'd255};
      IDX_W'(7):  c = '{8'd64,  8'd255, 8'd191};
      IDX_W'(8):  c = '{8'd128, 8'd255, 8'd128};
      IDX_W'(9):  c = '{8'd191, 8'd255, 8'd64};
      IDX_W'(10): c = '{8'd255, 8'd255, 8'd0};
      IDX_W'(11): c = '{8'd255, 8'd191, 8'd0};
      IDX_W'(12): c = '{8'd255, 8'd128, 8'd0};
      IDX_W'(13): c = '{8'd255, 8'd64,  8'd0};
      IDX_W'(14): c = '{8'd255, 8'd0,   8'd0};
      IDX_W'(15): c = '{8'd191, 8'd0,   8'd0};
      default:    c = '{8'd128, 8'd0,   8'd0};
    endcase
    palette_rgb = c;
  endfunction

endpackage

[hdl/mbet_ctrl.sv]
// ----------------------------------------------------------------------------
// mbet_ctrl
// sequencer: coordinate divide, multiply/update loop, result hand-off
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_time_pixel_defines.svh"

module mbet_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  mbet_pkg::mbet_sts_t sts_i,
  output mbet_pkg::mbet_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_MUL  = 5'b00100,
    S_CHK  = 5'b01000,
    S_DONE = 5'b10000
  } mbet_state_e;

  mbet_state_e                    state_q, state_d;
  logic [mbet_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                           out_valid_q, out_valid_d;
  mbet_pkg::mbet_cmd_t            cmd;
  logic                           div_last;

  assign div_last = (cnt_q == mbet_pkg::DIV_CNT_W'(mbet_pkg::DIV_STEPS - 1));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd     = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load = 1'b1;
          cnt_d    = '0;
          state_d  = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_d        = cnt_q + mbet_pkg::DIV_CNT_W'(1);
        if (div_last) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (sts_i.escape) begin
          state_d = S_DONE;
        end else begin
          cmd.upd = 1'b1;
          state_d = sts_i.k_last ? S_DONE : S_MUL;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.out_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  `MBET_ASSERT(a_no_result_overwrite, clk_i, rst_ni, cmd.out_load |-> (!out_valid_q || out_ready_i))
  `MBET_ASSERT_NEXT(a_accept_starts_div, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == S_DIV && cnt_q == '0)
  `MBET_ASSERT_NEXT(a_div_then_mul, clk_i, rst_ni, state_q == S_DIV && div_last, state_q == S_MUL)

endmodule

[hdl/mbet_dp.sv]
// ----------------------------------------------------------------------------
// mbet_dp
// coordinate dividers, complex square-add unit, result registers
// ----------------------------------------------------------------------------
module mbet_dp (
  input  logic                                clk_i,
  input  mbet_pkg::mbet_cmd_t                 cmd_i,
  output mbet_pkg::mbet_sts_t                 sts_o,
  input  logic [mbet_pkg::POS_W-1:0]          pixel_col_i,
  input  logic [mbet_pkg::POS_W-1:0]          pixel_row_i,
  input  logic [mbet_pkg::DIM_W-1:0]          image_width_i,
  input  logic [mbet_pkg::DIM_W-1:0]          image_height_i,
  output logic [mbet_pkg::ITER_W-1:0]         iter_count_o,
  output logic [mbet_pkg::IDX_W-1:0]          color_index_o,
  output logic [mbet_pkg::COLOR_W-1:0]        red_o,
  output logic [mbet_pkg::COLOR_W-1:0]        green_o,
  output logic [mbet_pkg::COLOR_W-1:0]        blue_o
);

  // lane 0 is the real axis, lane 1 the imaginary axis
  logic [mbet_pkg::DEN_W-1:0]     den_w [2];
  logic [mbet_pkg::DEN_W-1:0]     pos_w [2];
  logic [mbet_pkg::TRI_W-1:0]     tri_w [2];
  logic [mbet_pkg::DEN_W:0]       trial [2];
  logic                           ge    [2];
  logic [mbet_pkg::DEN_W-1:0]     den_q [2];
  logic [mbet_pkg::DEN_W-1:0]     rem_q [2];
  logic [mbet_pkg::DIV_STEPS-1:0] nq_q  [2];

  logic signed [mbet_pkg::Z_W-1:0]    zr_q, zi_q, cr, ci;
  logic signed [mbet_pkg::PROD_W-1:0] rr_q, ii_q, ri_q;
  logic [mbet_pkg::PROD_W:0]          mag;
  logic [mbet_pkg::ITER_W-1:0]        k_q;
  logic [mbet_pkg::IDX_W-1:0]         idx;
  mbet_pkg::mbet_rgb_t                rgb;

  logic [mbet_pkg::ITER_W-1:0]  iter_count_q;
  logic [mbet_pkg::IDX_W-1:0]   color_index_q;
  mbet_pkg::mbet_rgb_t          rgb_q;

  assign den_w[0] = mbet_pkg::den_of(image_width_i);
  assign den_w[1] = mbet_pkg::den_of(image_height_i);
  assign pos_w[0] = (pixel_col_i > den_w[0]) ? den_w[0] : pixel_col_i;
  assign pos_w[1] = (pixel_row_i > den_w[1]) ? den_w[1] : pixel_row_i;

  // numerator is 3*pos*2^28 + den/2, quotient below 2^30
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      tri_w[l] = mbet_pkg::TRI_W'(pos_w[l]) + mbet_pkg::TRI_W'({pos_w[l], 1'b0});
      trial[l] = {rem_q[l], nq_q[l][mbet_pkg::DIV_STEPS-1]};
      ge[l]    = (trial[l] >= {1'b0, den_q[l]});
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 2; l++) begin
      if (cmd_i.load) begin
        den_q[l] <= den_w[l];
        rem_q[l] <= tri_w[l][mbet_pkg::TRI_W-1:2];
        nq_q[l]  <= {tri_w[l][1:0], mbet_pkg::Q_FRAC'(den_w[l] >> 1)};
      end else if (cmd_i.div_step) begin
        rem_q[l] <= ge[l] ? mbet_pkg::DEN_W'(trial[l] - {1'b0, den_q[l]})
                          : trial[l][mbet_pkg::DEN_W-1:0];
        nq_q[l]  <= {nq_q[l][mbet_pkg::DIV_STEPS-2:0], ge[l]};
      end
    end
  end

  assign cr = mbet_pkg::RE_MIN + signed'(mbet_pkg::Z_W'(nq_q[0]));
  assign ci = mbet_pkg::IM_MIN + signed'(mbet_pkg::Z_W'(nq_q[1]));

  // squares are never negative, so the sum is compared unsigned
  assign mag = {1'b0, rr_q} + {1'b0, ii_q};

  assign sts_o.escape = (mag > mbet_pkg::ESCAPE_Q);
  assign sts_o.k_last = (k_q == mbet_pkg::ITER_W'(mbet_pkg::ITER_LIMIT - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      zr_q <= '0;
      zi_q <= '0;
      k_q  <= '0;
    end else if (cmd_i.upd) begin
      zr_q <= mbet_pkg::rescale(rr_q - ii_q) + cr;
      zi_q <= mbet_pkg::rescale(ri_q <<< 1) + ci;
      k_q  <= k_q + mbet_pkg::ITER_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      rr_q <= zr_q * zr_q;
      ii_q <= zi_q * zi_q;
      ri_q <= zr_q * zi_q;
    end
  end

  always_comb begin
    if (k_q == mbet_pkg::ITER_W'(mbet_pkg::ITER_LIMIT)) begin
      idx = '0;
    end else begin
      idx = mbet_pkg::IDX_W'(k_q % mbet_pkg::ITER_W'(mbet_pkg::PAL_MOD)) + mbet_pkg::IDX_W'(1);
    end
    rgb = mbet_pkg::palette_rgb(idx);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      iter_count_q  <= k_q;
      color_index_q <= idx;
      rgb_q         <= rgb;
    end
  end

  assign iter_count_o  = iter_count_q;
  assign color_index_o = color_index_q;
  assign red_o         = rgb_q.r;
  assign green_o       = rgb_q.g;
  assign blue_o        = rgb_q.b;

endmodule

[hdl/mandelbrot_escape_time_pixel.sv]
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel: escape-time evaluator for one pixel per beat
// one pixel is in the square-add loop at a time; the next is accepted once the
// previous result has moved into the output register
// reset: control and config (640 x 480) cleared asynchronously, no memories
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // register port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [mbet_pkg::ADDR_W-1:0]           paddr,
  input  logic [mbet_pkg::DATA_W-1:0]           pwdata,
  output logic [mbet_pkg::DATA_W-1:0]           prdata,
  output logic                                  pready,
  // pixel input
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [mbet_pkg::POS_W-1:0]            pixel_col_i,
  input  logic [mbet_pkg::POS_W-1:0]            pixel_row_i,
  // result output
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [mbet_pkg::ITER_W-1:0]           iter_count_o,
  output logic [mbet_pkg::IDX_W-1:0]            color_index_o,
  output logic [mbet_pkg::COLOR_W-1:0]          red_o,
  output logic [mbet_pkg::COLOR_W-1:0]          green_o,
  output logic [mbet_pkg::COLOR_W-1:0]          blue_o
);

  // flow per beat:
  //   accept, then radix-2 division mapping col/row to c (both axes run
  //   side by side), then per step a state to register the three 32x32
  //   products and a state for the escape test and z update, finally a
  //   move of the result into the output register.
  // the output register lets the next pixel start while a result waits.

  logic [mbet_pkg::DIM_W-1:0] width_q, height_q;
  logic                       wr_en;
  logic                       reg_sel;
  mbet_pkg::mbet_cmd_t        cmd;
  mbet_pkg::mbet_sts_t        sts;

  // ---------------------------------------------------------------------------
  // register port: two 13-bit registers at byte offsets 0 and 4
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= mbet_pkg::WIDTH_RST;
      height_q <= mbet_pkg::HEIGHT_RST;
    end else if (wr_en) begin
      case (reg_sel)
        mbet_pkg::REG_WIDTH:  width_q  <= pwdata[mbet_pkg::DIM_W-1:0];
        mbet_pkg::REG_HEIGHT: height_q <= pwdata[mbet_pkg::DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // read back, zero extended
  always_comb begin
    case (reg_sel)
      mbet_pkg::REG_WIDTH:  prdata = mbet_pkg::DATA_W'(width_q);
      mbet_pkg::REG_HEIGHT: prdata = mbet_pkg::DATA_W'(height_q);
      default:              prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer: issues at most one command per cycle, sees escape and last-step status
  // ---------------------------------------------------------------------------
  mbet_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // ---------------------------------------------------------------------------
  // datapath: user keeps config stable while a pixel is in flight (not enforced
  // by the block); the dividers read it straight from the registers at load
  // ---------------------------------------------------------------------------
  mbet_dp u_dp (
    .clk_i          (clk_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .pixel_col_i    (pixel_col_i),
    .pixel_row_i    (pixel_row_i),
    .image_width_i  (width_q),
    .image_height_i (height_q),
    .iter_count_o   (iter_count_o),
    .color_index_o  (color_index_o),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o)
  );

endmodule
